// ===== rtl/dul_pkg.sv =====
// ----------------------------------------------------------------------------
// dul_pkg
// Shared types, codes and constants of the door unlock controller.
// ----------------------------------------------------------------------------
package dul_pkg;

    // Field widths.
    localparam int TS_W       = 32;
    localparam int DEB_W      = 16;
    localparam int TIME_W     = 20;
    localparam int CNT_W      = 32;

    // Stream and configuration port widths.
    localparam int IN_W       = 40;
    localparam int OUT_W      = 72;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;

    // Blink phase: the elapsed time is divided by the half period through a
    // multiplication by its rounded-up reciprocal, in one registered stage.
    // Both reciprocals give the exact quotient over the whole 32-bit range.
    localparam int DIV_STAGES = 1;
    localparam int FAST_HALF  = 200 / 2;
    localparam int SLOW_HALF  = 2000 / 2;
    localparam int FAST_SHIFT = 37;
    localparam int SLOW_SHIFT = 38;
    localparam logic [TS_W-1:0] FAST_RECIP =
        TS_W'(((64'd1 << FAST_SHIFT) + 64'(FAST_HALF) - 64'd1) / 64'(FAST_HALF));
    localparam logic [TS_W-1:0] SLOW_RECIP =
        TS_W'(((64'd1 << SLOW_SHIFT) + 64'(SLOW_HALF) - 64'd1) / 64'(SLOW_HALF));

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RING      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNLOCK    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_COOLDOWN  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_RING_UNLK = 3'd4;

    typedef enum logic [2:0] {
        MODE_OFFLINE   = 3'd0,
        MODE_IDLE      = 3'd1,
        MODE_RING      = 3'd2,
        MODE_UNLOCKING = 3'd3,
        MODE_COOLDOWN  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        SND_NONE     = 2'd0,
        SND_RING     = 2'd1,
        SND_UNLOCKED = 2'd2,
        SND_DENIED   = 2'd3
    } t_sound;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_time;
        logic [TIME_W-1:0] ring_time;
        logic [TIME_W-1:0] unlock_time;
        logic [TIME_W-1:0] cooldown_time;
        logic              ring_timeout_unlocks;
    } t_cfg;

    typedef struct packed {
        logic [TS_W-1:0] timestamp;
        logic            button_level;
        logic            link_online;
        logic            unlock_request;
        logic            deny_request;
    } t_item;

    // One request on its way through the blink phase stage.
    typedef struct packed {
        logic             relay_on;
        t_sound           sound_code;
        t_mode            door_state;
        logic [CNT_W-1:0] unlocks_total;
        logic [CNT_W-1:0] rejected_total;
        logic             blink_en;
        logic             slow_blink;
        logic             led_fixed;
        logic [TS_W-1:0]  dividend;
        logic             qbit;
    } t_pipe;

endpackage

// ===== rtl/door_unlock_controller.sv =====
// ----------------------------------------------------------------------------
// door_unlock_controller
// Debounced door-bell button and remote-controlled door lock state machine.
// ----------------------------------------------------------------------------
// Pipeline: a request accepted at the input passes the input register, the
// state step and the blink phase stage before its result is on the output.
// Throughput: one request per cycle unless the output stalls. The state step
// is an unpipelined loop; the blink phase is a reciprocal product after it.
// Reset (synchronous, active low) empties the pipeline, puts the door offline
// with its state start time at zero and loads the default timeouts.
// ----------------------------------------------------------------------------
module door_unlock_controller
    import dul_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // Request stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] timestamp, [32] button_level, [33] link_online,
    // [34] unlock_request, [35] deny_request, [39:36] zero
    input  logic [IN_W-1:0]       s_axis_tdata,
    // Result stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] relay_on, [1] led_on, [3:2] sound_code, [6:4] door_state,
    // [38:7] unlocks_total, [70:39] rejected_total, [71] zero
    output logic [OUT_W-1:0]      m_axis_tdata
);

    localparam int NSTAGE = DIV_STAGES + 2;

    t_cfg        r_cfg;
    t_item       r_item;
    logic        r_valid [NSTAGE];
    logic        rdy     [NSTAGE];
    t_pipe       w_pipe  [DIV_STAGES+1];
    t_pipe       res;
    logic        led;

    // Configuration registers. Write them only while the block is idle; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time        <= DEB_W'(30);
            r_cfg.ring_time            <= TIME_W'(5000);
            r_cfg.unlock_time          <= TIME_W'(3000);
            r_cfg.cooldown_time        <= TIME_W'(2000);
            r_cfg.ring_timeout_unlocks <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_DEBOUNCE:  r_cfg.debounce_time        <= i_cfg_wdata[DEB_W-1:0];
                CFG_RING:      r_cfg.ring_time            <= i_cfg_wdata;
                CFG_UNLOCK:    r_cfg.unlock_time          <= i_cfg_wdata;
                CFG_COOLDOWN:  r_cfg.cooldown_time        <= i_cfg_wdata;
                CFG_RING_UNLK: r_cfg.ring_timeout_unlocks <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Each stage takes a new request when it is empty or the stage after it
    // moves on, so bubbles close up while the output is stalled.
    always_comb begin
        rdy[NSTAGE-1] = !r_valid[NSTAGE-1] || m_axis_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            rdy[k] = !r_valid[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTAGE; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else begin
            if (rdy[0]) begin
                r_valid[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (rdy[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && rdy[0]) begin
            r_item.timestamp      <= s_axis_tdata[TS_W-1:0];
            r_item.button_level   <= s_axis_tdata[TS_W];
            r_item.link_online    <= s_axis_tdata[TS_W+1];
            r_item.unlock_request <= s_axis_tdata[TS_W+2];
            r_item.deny_request   <= s_axis_tdata[TS_W+3];
        end
    end

    // The state machine steps exactly once for each request it passes on.
    dul_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_advance (r_valid[0] && rdy[1]),
        .i_item    (r_item),
        .o_pipe    (w_pipe[0])
    );

    // The elapsed time in the new state divided by the half blink period;
    // the LED is lit while that quotient is even.
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        dul_blink_stage u_stage (
            .i_clk  (i_clk),
            .i_load (r_valid[g+1] && rdy[g+2]),
            .i_pipe (w_pipe[g]),
            .o_pipe (w_pipe[g+1])
        );
    end

    assign res = w_pipe[DIV_STAGES];
    assign led = res.blink_en ? !res.qbit : res.led_fixed;

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = r_valid[NSTAGE-1];
    assign m_axis_tdata  = {1'b0, res.rejected_total, res.unlocks_total,
                            res.door_state, res.sound_code, led, res.relay_on};

endmodule

// ===== rtl/dul_core.sv =====
// ----------------------------------------------------------------------------
// dul_core
// Button debouncer and door state machine; one request per advance.
// ----------------------------------------------------------------------------
module dul_core
    import dul_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_advance,
    input  t_item i_item,
    output t_pipe o_pipe
);

    logic             r_raw_level;
    logic             r_stable_level;
    logic [TS_W-1:0]  r_raw_changed_at;
    t_mode            r_mode;
    logic [TS_W-1:0]  r_mode_since;
    logic [CNT_W-1:0] r_unlocks;
    logic [CNT_W-1:0] r_rejected;
    t_pipe            r_pipe;

    logic             n_raw_level;
    logic             n_stable_level;
    logic [TS_W-1:0]  n_raw_changed_at;
    t_mode            n_mode;
    logic [TS_W-1:0]  n_mode_since;
    logic [CNT_W-1:0] n_unlocks;
    logic [CNT_W-1:0] n_rejected;
    t_pipe            n_pipe;

    logic             press;
    logic [TS_W-1:0]  elapsed;
    logic             go;
    logic             deny_sound;
    logic             reject;
    t_mode            target;

    // Debounce.
    always_comb begin
        n_raw_level      = i_item.button_level;
        n_raw_changed_at = r_raw_changed_at;
        if (i_item.button_level != r_raw_level) begin
            n_raw_changed_at = i_item.timestamp;
        end
        n_stable_level = r_stable_level;
        press          = 1'b0;
        if ((n_raw_level != r_stable_level) &&
            ((i_item.timestamp - n_raw_changed_at) >= TS_W'(i_cfg.debounce_time))) begin
            n_stable_level = n_raw_level;
            press          = n_raw_level;
        end
    end

    assign elapsed = i_item.timestamp - r_mode_since;

    // Next state of the door machine.
    always_comb begin
        go         = 1'b0;
        target     = r_mode;
        deny_sound = 1'b0;
        reject     = 1'b0;
        unique case (r_mode)
            MODE_IDLE: begin
                if (!i_item.link_online) begin
                    go = 1'b1; target = MODE_OFFLINE;
                end else if (i_item.unlock_request) begin
                    go = 1'b1; target = MODE_UNLOCKING;
                end else if (press) begin
                    go = 1'b1; target = MODE_RING;
                end else if (i_item.deny_request) begin
                    deny_sound = 1'b1;
                end
            end
            MODE_RING: begin
                if (i_item.unlock_request) begin
                    go = 1'b1; target = MODE_UNLOCKING;
                end else if (i_item.deny_request) begin
                    deny_sound = 1'b1;
                    go = 1'b1; target = MODE_IDLE;
                end else if (elapsed >= TS_W'(i_cfg.ring_time)) begin
                    go = 1'b1;
                    if (i_cfg.ring_timeout_unlocks) begin
                        target = MODE_UNLOCKING;
                    end else begin
                        target = i_item.link_online ? MODE_IDLE : MODE_OFFLINE;
                    end
                end
            end
            MODE_UNLOCKING: begin
                reject = i_item.unlock_request;
                if (elapsed >= TS_W'(i_cfg.unlock_time)) begin
                    go = 1'b1; target = MODE_COOLDOWN;
                end
            end
            MODE_COOLDOWN: begin
                reject = i_item.unlock_request;
                if (elapsed >= TS_W'(i_cfg.cooldown_time)) begin
                    go = 1'b1;
                    target = i_item.link_online ? MODE_IDLE : MODE_OFFLINE;
                end
            end
            default: begin
                // Offline, and any code that cannot arise.
                target = MODE_OFFLINE;
                if (i_item.link_online) begin
                    go = 1'b1; target = MODE_IDLE;
                end else if (press) begin
                    go = 1'b1; target = MODE_RING;
                end else if (i_item.unlock_request) begin
                    go = 1'b1; target = MODE_UNLOCKING;
                end
            end
        endcase
    end

    // Outputs of the step.
    always_comb begin
        n_mode       = target;
        n_mode_since = go ? i_item.timestamp : r_mode_since;
        n_unlocks    = r_unlocks + CNT_W'(go && (target == MODE_UNLOCKING));
        n_rejected   = r_rejected + CNT_W'(reject);

        n_pipe                = '0;
        n_pipe.relay_on       = (n_mode == MODE_UNLOCKING);
        n_pipe.door_state     = n_mode;
        n_pipe.unlocks_total  = n_unlocks;
        n_pipe.rejected_total = n_rejected;
        n_pipe.dividend       = i_item.timestamp - n_mode_since;
        n_pipe.sound_code     = SND_NONE;
        if (go && (target == MODE_RING)) begin
            n_pipe.sound_code = SND_RING;
        end else if (go && (target == MODE_UNLOCKING)) begin
            n_pipe.sound_code = SND_UNLOCKED;
        end else if (deny_sound) begin
            n_pipe.sound_code = SND_DENIED;
        end
        unique case (n_mode)
            MODE_IDLE:      n_pipe.led_fixed = 1'b0;
            MODE_RING:      n_pipe.blink_en  = 1'b1;
            MODE_UNLOCKING: n_pipe.led_fixed = 1'b1;
            MODE_COOLDOWN:  n_pipe.led_fixed = 1'b0;
            default: begin
                n_pipe.blink_en   = 1'b1;
                n_pipe.slow_blink = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_level      <= 1'b0;
            r_stable_level   <= 1'b0;
            r_raw_changed_at <= '0;
            r_mode           <= MODE_OFFLINE;
            r_mode_since     <= '0;
            r_unlocks        <= '0;
            r_rejected       <= '0;
        end else if (i_advance) begin
            r_raw_level      <= n_raw_level;
            r_stable_level   <= n_stable_level;
            r_raw_changed_at <= n_raw_changed_at;
            r_mode           <= n_mode;
            r_mode_since     <= n_mode_since;
            r_unlocks        <= n_unlocks;
            r_rejected       <= n_rejected;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_pipe = r_pipe;

endmodule

// ===== rtl/dul_blink_stage.sv =====
// ----------------------------------------------------------------------------
// dul_blink_stage
// Blink phase stage: elapsed time over the half period by reciprocal product.
// ----------------------------------------------------------------------------
module dul_blink_stage
    import dul_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_load,
    input  t_pipe i_pipe,
    output t_pipe o_pipe
);

    t_pipe             r_pipe;
    t_pipe             n_pipe;
    logic [TS_W-1:0]   recip;
    logic [2*TS_W-1:0] product;

    // The lowest bit of the quotient is the blink phase; it sits at the
    // shift position of the chosen reciprocal.
    always_comb begin
        n_pipe      = i_pipe;
        recip       = i_pipe.slow_blink ? SLOW_RECIP : FAST_RECIP;
        product     = (2*TS_W)'(i_pipe.dividend) * (2*TS_W)'(recip);
        n_pipe.qbit = i_pipe.slow_blink ? product[SLOW_SHIFT] : product[FAST_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_pipe = r_pipe;

endmodule

// ===== rtl/dul_checker.sv =====
// ----------------------------------------------------------------------------
// dul_checker
// Port-level assertions for the door unlock controller, bound to the top.
// ----------------------------------------------------------------------------
module dul_checker
    import dul_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // A result held back by the sink stays unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // No result is offered right after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result offered after reset");

    // The relay is energised exactly in the unlocking state.
    a_relay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[6:4] == MODE_UNLOCKING)))
        else $error("relay does not follow the unlocking state");

    // The unlocked sound only comes on entry to unlocking, which lights the LED.
    a_unlock_snd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[3:2] == SND_UNLOCKED)
        |-> (m_axis_tdata[6:4] == MODE_UNLOCKING) && m_axis_tdata[1])
        else $error("unlocked sound outside unlocking");

    // The ring sound only comes on entry to local ring, in the lit blink phase.
    a_ring_snd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[3:2] == SND_RING)
        |-> (m_axis_tdata[6:4] == MODE_RING) && m_axis_tdata[1])
        else $error("ring sound outside local ring");

endmodule

bind door_unlock_controller dul_checker u_dul_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
